[rtl/core/tlzw_pkg.sv]
// Shared types and constants of the TIFF LZW byte compressor.
package tlzw_pkg;

  localparam logic [11:0] CODE_NONE  = 12'd4095;
  localparam logic [11:0] CODE_CLEAR = 12'd256;
  localparam logic [11:0] CODE_END   = 12'd257;
  localparam logic [11:0] CODE_FIRST = 12'd258;
  localparam logic [3:0]  WIDTH_MIN  = 4'd9;
  localparam logic [3:0]  WIDTH_MAX  = 4'd12;
  localparam logic [4:0]  BUF_BITS   = 5'd24;
  localparam logic [4:0]  BYTE_LIMIT = 5'd16;
  localparam logic [7:0]  BYTE_MASK  = 8'hFF;

  localparam logic [1:0] CFG_PREDICT   = 2'd0;
  localparam logic [1:0] CFG_CLEAR_END = 2'd1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_start;
    logic       strip_end;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       strip_done;
  } dst_item_t;

  typedef struct packed {
    logic [7:0]  suffix;
    logic [11:0] less;
    logic [11:0] greater;
    logic [11:0] prefix;
  } node_t;

endpackage

[rtl/core/tiff_lzw_byte_compressor.sv]
// TIFF LZW byte compressor: differencing, dictionary tree walk and MSB-first code packing.
//
// One pixel is taken per transaction and src_stall stays high until every byte it causes
// has been handed to the output register. The work per item grows with each tree node
// visited in the dictionary memory (no walk is needed when the byte starts a new string),
// with an insertion into the tree, with a further write when the new node hangs below a
// node rather than the prefix root, and with each emitted code and each emitted byte.
// Strip openings, table clears and strip ends add control states, and output stalls add
// their own length. The walk is bound by the registered read of the node memory. Stale
// prefix roots after a table clear are rejected by checking the node's stored prefix and
// the free-code count, so no clearing pass is needed.
module tiff_lzw_byte_compressor #(
  parameter int TABLE_CODES = 4094
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  tlzw_pkg::src_item_t  src_item,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output tlzw_pkg::dst_item_t  dst_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic                 cfg_data
);
  import tlzw_pkg::*;

  localparam logic [11:0] TableLimit = 12'(TABLE_CODES);

  typedef enum logic [4:0] {
    S_IDLE, S_OPEN_B, S_LOOKUP, S_ROOT_WAIT, S_NODE_WAIT, S_INSERT, S_INSERT2,
    S_TCLR_B, S_ENDCHK, S_END_A, S_END_B, S_END_C, S_END_D, S_PUT, S_EMIT, S_FINISH
  } state_t;

  state_t      state, ret;
  logic        predict_enable, clear_at_strip_end, strip_open, strip_end, flush;
  logic [7:0]  b, previous_pixel, hold;
  logic        hold_valid;
  logic [11:0] cur, nfc, code_reg, link_at, pcode;
  logic        link_root, link_less;
  node_t       link_nd;
  logic [3:0]  cw;
  logic [23:0] bit_buffer;
  logic [4:0]  free_pos;

  logic [11:0] root_mem [4096];
  node_t       node_mem [4096];
  logic [11:0] root_q;
  node_t       node_q;

  logic        root_we, node_we;
  logic [11:0] root_raddr, root_waddr, root_wdata, node_raddr, node_waddr;
  node_t       node_wdata;

  logic        out_free, hit, prefix_ok, code_ok, table_room, dst_load;
  logic [11:0] child;
  logic [7:0]  prev_eff, b_in;
  logic [11:0] nfc_inc, code_mask;
  logic [23:0] put_bits;
  logic [4:0]  emit_limit;

  assign cfg_ready  = 1'b1;
  assign src_stall  = (state != S_IDLE);
  assign out_free   = !dst_valid || !dst_stall;
  assign hit        = (node_q.suffix == b);
  assign child      = (node_q.suffix > b) ? node_q.less : node_q.greater;
  assign prefix_ok  = !link_root || (node_q.prefix == link_at);
  assign code_ok    = (root_q >= CODE_FIRST) && (root_q < nfc);
  assign table_room = (nfc < TableLimit);
  assign nfc_inc    = nfc + 12'd1;
  assign prev_eff   = src_item.row_start ? 8'd0 : previous_pixel;
  assign b_in       = predict_enable ? 8'(src_item.pixel - prev_eff) : src_item.pixel;
  assign code_mask  = 12'((13'd1 << cw) - 13'd1);
  assign put_bits   = {12'd0, pcode & code_mask} << (free_pos - {1'b0, cw});
  assign emit_limit = flush ? BUF_BITS : BYTE_LIMIT;
  assign dst_load   = hold_valid && out_free &&
                      (((state == S_EMIT) && (free_pos < emit_limit)) || (state == S_FINISH));

  always_comb begin
    root_raddr = cur;
    node_raddr = (state == S_ROOT_WAIT) ? root_q : child;
    root_we    = (state == S_INSERT) && table_room && link_root;
    root_waddr = link_at;
    root_wdata = nfc;
    node_we    = 1'b0;
    node_waddr = nfc;
    node_wdata = '{suffix: b, less: CODE_NONE, greater: CODE_NONE, prefix: cur};
    if (state == S_INSERT && table_room) begin
      node_we = 1'b1;
    end else if (state == S_INSERT2) begin
      node_we    = 1'b1;
      node_waddr = link_at;
      node_wdata = link_nd;
      if (link_less) begin
        node_wdata.less = code_reg;
      end else begin
        node_wdata.greater = code_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[root_waddr] <= root_wdata;
    end
    root_q <= root_mem[root_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ret                <= S_IDLE;
      predict_enable     <= 1'b0;
      clear_at_strip_end <= 1'b1;
      strip_open         <= 1'b0;
      flush              <= 1'b0;
      previous_pixel     <= 8'd0;
      hold_valid         <= 1'b0;
      dst_valid          <= 1'b0;
      cur                <= CODE_NONE;
      nfc                <= CODE_FIRST;
      cw                 <= WIDTH_MIN;
      bit_buffer         <= 24'd0;
      free_pos           <= BUF_BITS;
    end else begin
      if (dst_load) begin
        dst_valid <= 1'b1;
      end else if (dst_valid && !dst_stall) begin
        dst_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PREDICT:   predict_enable <= cfg_data;
          CFG_CLEAR_END: clear_at_strip_end <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (src_valid) begin
            b              <= b_in;
            strip_end      <= src_item.strip_end;
            previous_pixel <= src_item.pixel;
            if (!strip_open) begin
              bit_buffer <= 24'd0;
              free_pos   <= BUF_BITS;
              cw         <= WIDTH_MIN;
              pcode      <= CODE_CLEAR;
              ret        <= S_OPEN_B;
              state      <= S_PUT;
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_OPEN_B: begin
          nfc        <= CODE_FIRST;
          cw         <= WIDTH_MIN;
          cur        <= CODE_NONE;
          strip_open <= 1'b1;
          state      <= S_LOOKUP;
        end
        S_LOOKUP: begin
          if (cur == CODE_NONE) begin
            cur   <= {4'd0, b};
            state <= S_ENDCHK;
          end else begin
            state <= S_ROOT_WAIT;
          end
        end
        S_ROOT_WAIT: begin
          link_root <= 1'b1;
          link_at   <= cur;
          code_reg  <= root_q;
          if (code_ok) begin
            state <= S_NODE_WAIT;
          end else begin
            pcode <= cur;
            ret   <= S_INSERT;
            state <= S_PUT;
          end
        end
        S_NODE_WAIT: begin
          if (!prefix_ok) begin
            pcode <= cur;
            ret   <= S_INSERT;
            state <= S_PUT;
          end else if (hit) begin
            cur   <= code_reg;
            state <= S_ENDCHK;
          end else begin
            link_root <= 1'b0;
            link_less <= (node_q.suffix > b);
            link_at   <= code_reg;
            link_nd   <= node_q;
            code_reg  <= child;
            if (child == CODE_NONE) begin
              pcode <= cur;
              ret   <= S_INSERT;
              state <= S_PUT;
            end
          end
        end
        S_INSERT: begin
          if (table_room) begin
            code_reg <= nfc;
            nfc      <= nfc_inc;
            if (cw < WIDTH_MAX && {1'b0, nfc_inc} >= (13'd1 << cw)) begin
              cw <= cw + 4'd1;
            end
            cur   <= {4'd0, b};
            state <= link_root ? S_ENDCHK : S_INSERT2;
          end else begin
            pcode <= CODE_CLEAR;
            ret   <= S_TCLR_B;
            state <= S_PUT;
          end
        end
        S_INSERT2: state <= S_ENDCHK;
        S_TCLR_B: begin
          cw    <= WIDTH_MIN;
          nfc   <= CODE_FIRST;
          cur   <= {4'd0, b};
          state <= S_ENDCHK;
        end
        S_ENDCHK: begin
          if (strip_end) begin
            pcode <= cur;
            ret   <= S_END_A;
            state <= S_PUT;
          end else begin
            state <= S_FINISH;
          end
        end
        S_END_A: begin
          if (clear_at_strip_end) begin
            pcode <= CODE_CLEAR;
            ret   <= S_END_B;
            state <= S_PUT;
          end else begin
            state <= S_END_B;
          end
        end
        S_END_B: begin
          if (clear_at_strip_end) begin
            cw  <= WIDTH_MIN;
            nfc <= CODE_FIRST;
            cur <= CODE_NONE;
          end
          pcode <= CODE_END;
          ret   <= S_END_C;
          state <= S_PUT;
        end
        S_END_C: begin
          cw    <= WIDTH_MIN;
          flush <= 1'b1;
          ret   <= S_END_D;
          state <= S_EMIT;
        end
        S_END_D: begin
          flush      <= 1'b0;
          bit_buffer <= 24'd0;
          free_pos   <= BUF_BITS;
          strip_open <= 1'b0;
          state      <= S_FINISH;
        end
        S_PUT: begin
          bit_buffer <= bit_buffer | put_bits;
          free_pos   <= free_pos - {1'b0, cw};
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (free_pos < emit_limit) begin
            if (!hold_valid || out_free) begin
              if (hold_valid) begin
                dst_item <= '{out_byte: hold, last_of_run: 1'b0, strip_done: 1'b0};
              end
              hold       <= bit_buffer[23:16] & BYTE_MASK;
              hold_valid <= 1'b1;
              bit_buffer <= {bit_buffer[15:0], 8'd0};
              free_pos   <= free_pos + 5'd8;
            end
          end else begin
            state <= ret;
          end
        end
        S_FINISH: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            dst_item   <= '{out_byte: hold, last_of_run: 1'b1, strip_done: strip_end};
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_tiff_lzw_byte_compressor.sv]
// Testbench for tiff_lzw_byte_compressor: directed and random pixel strips checked against an LZW predictor.
`timescale 1ns / 1ps

module tb_tiff_lzw_byte_compressor;
  import tlzw_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd2;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int TBL_CODES = 4094;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  src_item_t src_item = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  dst_item_t dst_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  tiff_lzw_byte_compressor u_top (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_item(dst_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // LZW predictor state
  logic [11:0] dict_root [4096];
  logic [7:0]  dict_suffix [4096];
  logic [11:0] dict_less [4096];
  logic [11:0] dict_greater [4096];
  int unsigned cur_string, free_code, code_bits, free_pos;
  logic [23:0] bit_acc;
  logic [7:0] prev_pixel;
  bit strip_is_open;
  bit pred_on = 1'b0;
  bit clear_on_end = 1'b1;

  logic [7:0] byte_run[$];
  dst_item_t  expected_bytes[$];

  int fails = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_left = 0;

  task automatic pack_code(input int unsigned code);
    code = code & ((1 << code_bits) - 1);
    free_pos -= code_bits;
    bit_acc = bit_acc | 24'(code << free_pos);
    while (free_pos < 16) begin
      if (byte_run.size() < 10) byte_run.push_back(bit_acc[23:16]);
      bit_acc = bit_acc << 8;
      free_pos += 8;
    end
  endtask

  task automatic restart_dict();
    pack_code(CODE_CLEAR);
    code_bits = 9;
    free_code = CODE_FIRST;
    cur_string = CODE_NONE;
    for (int i = 0; i < 4096; i++) dict_root[i] = CODE_NONE;
  endtask

  task automatic lzw_byte(input logic [7:0] b);
    int unsigned code, link_at;
    int link_kind;
    link_kind = 0;
    if (cur_string == CODE_NONE) begin
      cur_string = b;
      return;
    end
    link_at = cur_string;
    code = dict_root[link_at];
    while (code != CODE_NONE && dict_suffix[code] != b) begin
      link_at = code;
      if (dict_suffix[code] > b) begin
        link_kind = 1;
        code = dict_less[code];
      end else begin
        link_kind = 2;
        code = dict_greater[code];
      end
    end
    if (code != CODE_NONE) begin
      cur_string = code;
      return;
    end
    pack_code(cur_string);
    if (free_code < TBL_CODES) begin
      code = free_code;
      free_code++;
      if (code_bits < 12 && free_code >= (1 << code_bits)) code_bits++;
      dict_suffix[code] = b;
      dict_less[code] = CODE_NONE;
      dict_greater[code] = CODE_NONE;
      if (link_kind == 0) dict_root[link_at] = 12'(code);
      else if (link_kind == 1) dict_less[link_at] = 12'(code);
      else dict_greater[link_at] = 12'(code);
    end else begin
      restart_dict();
    end
    cur_string = b;
  endtask

  task automatic predict_bytes(input src_item_t it);
    logic [7:0] b;
    dst_item_t r;
    byte_run.delete();
    if (!strip_is_open) begin
      bit_acc = '0;
      free_pos = 24;
      code_bits = 9;
      restart_dict();
      strip_is_open = 1'b1;
    end
    if (it.row_start) prev_pixel = '0;
    b = pred_on ? it.pixel - prev_pixel : it.pixel;
    prev_pixel = it.pixel;
    lzw_byte(b);
    if (it.strip_end) begin
      pack_code(cur_string);
      if (clear_on_end) restart_dict();
      pack_code(CODE_END);
      code_bits = 9;
      while (free_pos < 24) begin
        if (byte_run.size() < 10) byte_run.push_back(bit_acc[23:16]);
        bit_acc = bit_acc << 8;
        free_pos += 8;
      end
      bit_acc = '0;
      free_pos = 24;
      strip_is_open = 1'b0;
    end
    foreach (byte_run[i]) begin
      r.out_byte = byte_run[i];
      r.last_of_run = (i == byte_run.size() - 1);
      r.strip_done = r.last_of_run && it.strip_end;
      expected_bytes.push_back(r);
    end
  endtask

  initial begin
    for (int i = 0; i < 4096; i++) begin
      dict_root[i] = CODE_NONE;
      dict_suffix[i] = '0;
      dict_less[i] = '0;
      dict_greater[i] = '0;
    end
    cur_string = CODE_NONE;
    free_code = CODE_FIRST;
    code_bits = 9;
    bit_acc = '0;
    free_pos = 24;
    prev_pixel = '0;
    strip_is_open = 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    dst_item_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_bytes.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected byte %h", dst_item);
      end else begin
        want = expected_bytes.pop_front();
        if (want !== dst_item) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp byte %h last %b done %b, got byte %h last %b done %b",
                     want.out_byte, want.last_of_run, want.strip_done,
                     dst_item.out_byte, dst_item.last_of_run, dst_item.strip_done);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      dst_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      dst_stall <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  // caller is at a falling edge; returns at a falling edge with valid still high
  task automatic send_pixel(input logic [7:0] px, input bit row, input bit last);
    src_item_t it;
    it.pixel = px;
    it.row_start = row;
    it.strip_end = last;
    if ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item <= it;
    do @(posedge clk); while (src_stall);
    predict_bytes(it);
    @(negedge clk);
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    wait (expected_bytes.size() == 0);
    @(negedge clk);
    while (src_stall) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input bit val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PREDICT) pred_on = val;
    else if (idx == CFG_CLEAR_END) clear_on_end = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // smooth rows so that strings repeat, with occasional noise
  task automatic send_strip(input int len);
    logic [7:0] px;
    int row_len;
    px = 8'($urandom);
    row_len = $urandom_range(3, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) px = 8'($urandom);
      else px = 8'(px + $urandom_range(0, 2) - 1);
      send_pixel(px, (i % row_len) == 0, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_pixel(8'h00, 1'b1, 1'b1);
    send_pixel(8'hFF, 1'b1, 1'b1);
    send_pixel(8'h00, 1'b1, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b1);
    drain();
    write_reg(CFG_PREDICT, 1'b1);
    write_reg(CFG_CLEAR_END, 1'b0);
    write_reg(CFG_SPARE, 1'b1);
    write_reg(CFG_UNUSED, 1'b0);
    send_pixel(8'h55, 1'b0, 1'b0);   // no row start: differencing from stale pixel
    send_pixel(8'hAA, 1'b0, 1'b0);
    send_pixel(8'h01, 1'b1, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b0);
    send_pixel(8'h80, 1'b1, 1'b0);
    send_pixel(8'h7F, 1'b0, 1'b1);
    send_pixel(8'h10, 1'b0, 1'b1);
    drain();
    write_reg(CFG_CLEAR_END, 1'b1);
  endtask

  task automatic test_random(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 15);
      send_strip(len);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    send_strip(25);
    drain();
    send_strip(6);
    src_valid <= 1'b0;
    wait (expected_bytes.size() == 0);
    @(negedge clk);
    send_strip(6);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    src_idle_pct = 26;
    dst_idle_pct = 71;
    test_random(35);
    drain();
    write_reg(CFG_PREDICT, 1'b0);
    src_idle_pct = 71;
    dst_idle_pct = 26;
    test_random(35);
    drain();
    write_reg(CFG_PREDICT, 1'b1);
    write_reg(CFG_CLEAR_END, 1'b0);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random(35);
    drain();
    test_backpressure();
    wait (expected_bytes.size() == 0);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
